>>> hw/rtl/bc1_block_decoder_macros.svh
// Assertion macros shared by the block decoder's checker.
`ifndef BC1_BLOCK_DECODER_MACROS_SVH
`define BC1_BLOCK_DECODER_MACROS_SVH

// Concurrent assertion that is held off while reset is asserted.
`define BC1_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during and right after reset.
`define BC1_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bc1_pkg.sv
// Shared types, constants and palette functions of the BC1 block decoder.
package bc1_pkg;

   // Number of texels in one 4x4 block and the width of a texel counter.
   localparam int TEXELS      = 16;
   localparam int TEXEL_CNT_W = $clog2(TEXELS);

   // Default depth of the queue between the front and back parts.
   localparam int Q_DEPTH = 2;

   // Alpha codes.
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   // Division by three as a multiply by a reciprocal, exact for inputs below 2048.
   localparam int          RECIP3_SHIFT = 11;
   localparam logic [9:0]  RECIP3       = 10'd683;

   // One RGBA8 color.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   // One classified block: its four palette colors and its index word.
   typedef struct packed {
      color_type [3:0] pal;
      logic [31:0]     index_bits;
   } entry_type;

   // Status of the queue as seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Truncating division by three of a 9-bit value.
   function automatic logic [7:0] div3(input logic [8:0] x);
      logic [18:0] prod;
      prod = 19'(x) * 19'(RECIP3);
      return prod[RECIP3_SHIFT +: 8];
   endfunction

   // Expand an RGB565 endpoint to an opaque RGBA8 color by plain shifts.
   function automatic color_type expand565(input logic [15:0] v);
      color_type c;
      c.red   = {v[15:11], 3'b000};
      c.green = {v[10:5], 2'b00};
      c.blue  = {v[4:0], 3'b000};
      c.alpha = ALPHA_OPAQUE;
      return c;
   endfunction

   // Two-thirds of a plus one-third of b, each term truncated on its own.
   function automatic logic [7:0] third_mix(input logic [7:0] a, input logic [7:0] b);
      return div3({a, 1'b0}) + div3({1'b0, b});
   endfunction

   // Half of a plus half of b, each term truncated on its own.
   function automatic logic [7:0] half_mix(input logic [7:0] a, input logic [7:0] b);
      return {1'b0, a[7:1]} + {1'b0, b[7:1]};
   endfunction

endpackage

>>> hw/rtl/bc1_req_if.sv
// Channel that carries compressed blocks into the decoder.
interface bc1_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] endpoint_zero;
   logic [15:0] endpoint_one;
   logic [31:0] index_bits;

   modport source (output valid, output endpoint_zero, output endpoint_one,
                   output index_bits, input ready);
   modport sink   (input valid, input endpoint_zero, input endpoint_one,
                   input index_bits, output ready);
endinterface

>>> hw/rtl/bc1_rsp_if.sv
// Channel that carries decoded texels out of the decoder.
interface bc1_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [1:0] texel_col;
   logic [1:0] texel_row;
   logic       last_texel;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output texel_col, output texel_row, output last_texel, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input texel_col, input texel_row, input last_texel, output ready);
endinterface

>>> hw/rtl/bc1_front.sv
// Front part: accepts a compressed block and builds its four-color palette.
module bc1_front import bc1_pkg::*; (
   bc1_req_if.sink    req_chan,
   input  q_stat_type q_stat,
   output logic       push,
   output entry_type  push_entry
);

   color_type c0;
   color_type c1;
   logic      four_color;

   // A block is taken whenever the queue has room.
   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

   // Expand endpoints and choose the palette mode.
   always_comb begin
      c0         = expand565(req_chan.endpoint_zero);
      c1         = expand565(req_chan.endpoint_one);
      four_color = req_chan.endpoint_zero > req_chan.endpoint_one;

      push_entry.pal[0]     = c0;
      push_entry.pal[1]     = c1;
      push_entry.index_bits = req_chan.index_bits;
      if (four_color) begin
         push_entry.pal[2].red   = third_mix(c0.red, c1.red);
         push_entry.pal[2].green = third_mix(c0.green, c1.green);
         push_entry.pal[2].blue  = third_mix(c0.blue, c1.blue);
         push_entry.pal[2].alpha = ALPHA_OPAQUE;
         push_entry.pal[3].red   = third_mix(c1.red, c0.red);
         push_entry.pal[3].green = third_mix(c1.green, c0.green);
         push_entry.pal[3].blue  = third_mix(c1.blue, c0.blue);
         push_entry.pal[3].alpha = ALPHA_OPAQUE;
      end else begin
         push_entry.pal[2].red   = half_mix(c0.red, c1.red);
         push_entry.pal[2].green = half_mix(c0.green, c1.green);
         push_entry.pal[2].blue  = half_mix(c0.blue, c1.blue);
         push_entry.pal[2].alpha = ALPHA_OPAQUE;
         push_entry.pal[3].red   = 8'h00;
         push_entry.pal[3].green = 8'h00;
         push_entry.pal[3].blue  = 8'h00;
         push_entry.pal[3].alpha = ALPHA_CLEAR;
      end
   end

endmodule

>>> hw/rtl/bc1_queue.sv
// Short queue of classified blocks between the front and back parts.
module bc1_queue import bc1_pkg::*; #(
   parameter int DEPTH = Q_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output q_stat_type q_stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign q_stat.full  = count_ff == CNT_W'(DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign head         = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/bc1_back.sv
// Back part: walks the sixteen texels of the head block into the output register.
module bc1_back import bc1_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  q_stat_type q_stat,
   output logic       pop,
   bc1_rsp_if.source  rsp_chan
);

   logic [TEXEL_CNT_W-1:0] texel_ff;
   logic [TEXEL_CNT_W-1:0] texel_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   load;
   logic [TEXEL_CNT_W-1:0] rev_pos;
   logic [1:0]             sel;
   color_type              color_ff;
   logic [1:0]             col_ff;
   logic [1:0]             row_ff;
   logic                   last_ff;
   logic                   is_last;

   // The output register takes a new texel when empty or being drained.
   assign load    = !q_stat.empty && (!valid_ff || rsp_chan.ready);
   assign is_last = texel_ff == TEXEL_CNT_W'(TEXELS - 1);
   assign pop     = load && is_last;

   // Row 0 sits in the top byte and column 0 in the top pair of a byte.
   assign rev_pos = ~texel_ff;
   assign sel     = head.index_bits[{rev_pos, 1'b0} +: 2];

   // Control state updates.
   always_comb begin
      texel_in = load ? texel_ff + 1'b1 : texel_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         texel_ff <= texel_in;
         valid_ff <= valid_in;
      end
   end

   // Texel payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= head.pal[sel];
         row_ff   <= texel_ff[3:2];
         col_ff   <= texel_ff[1:0];
         last_ff  <= is_last;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.red        = color_ff.red;
   assign rsp_chan.green      = color_ff.green;
   assign rsp_chan.blue       = color_ff.blue;
   assign rsp_chan.alpha      = color_ff.alpha;
   assign rsp_chan.texel_col  = col_ff;
   assign rsp_chan.texel_row  = row_ff;
   assign rsp_chan.last_texel = last_ff;

endmodule

>>> hw/rtl/bc1_block_decoder.sv
// Top level of the BC1 block decoder.
//
//   channel   direction  payload                                       transfer
//   req_chan  in         endpoint_zero, endpoint_one, index_bits       one block
//   rsp_chan  out        red, green, blue, alpha, texel_col/row, last  one texel
//
// A block yields sixteen texels, one per cycle while rsp_chan is ready; the back
// part's texel walk and its single output register set that rate.
// A block is taken on the cycle it arrives while the queue has room, and its first
// texel enters the output register once that register is empty or being drained.
// Reset is synchronous and clears the queue pointers, texel counter and output valid.
// A stalled rsp_chan holds the texel; the queue keeps taking blocks until it is full.
module bc1_block_decoder import bc1_pkg::*; #(
   parameter int QUEUE_DEPTH = Q_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   bc1_req_if.sink   req_chan,
   bc1_rsp_if.source rsp_chan
);

   logic       push;
   logic       pop;
   entry_type  push_entry;
   entry_type  head;
   q_stat_type q_stat;

   // Palette builder.
   bc1_front u_front (
      .req_chan   (req_chan),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   // Block queue.
   bc1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Texel sequencer.
   bc1_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> hw/rtl/bc1_checker.sv
// Port-level checker for the BC1 block decoder and its bind.
`include "bc1_block_decoder_macros.svh"

module bc1_checker import bc1_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic [1:0] rsp_texel_col,
   input logic [1:0] rsp_texel_row,
   input logic       rsp_last_texel
);

   logic [TEXEL_CNT_W-1:0] seen_ff;
   logic [35:0]            payload;
   logic [35:0]            payload_ff;
   logic                   pos_ok;
   logic                   alpha_ok;
   logic                   stalled;
   logic                   hold_ok;

   // Count texel transfers to know where in the block the next one falls.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= seen_ff + 1'b1;
      end
   end

   // Keep the previous payload to check that a stalled texel holds still.
   always_ff @(posedge clock) begin
      payload_ff <= payload;
   end

   assign payload  = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_texel_col, rsp_texel_row};
   assign pos_ok   = (rsp_texel_row == seen_ff[3:2]) && (rsp_texel_col == seen_ff[1:0]) &&
                     (rsp_last_texel == (seen_ff == TEXEL_CNT_W'(TEXELS - 1)));
   assign alpha_ok = (rsp_alpha == ALPHA_OPAQUE) ||
                     ((rsp_alpha == ALPHA_CLEAR) && (rsp_red == 8'h00) &&
                      (rsp_green == 8'h00) && (rsp_blue == 8'h00));
   assign stalled  = rsp_valid && !rsp_ready;
   assign hold_ok  = rsp_valid && (payload == payload_ff);

   `BC1_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "texel after reset")

   `BC1_ASSERT(a_texel_order, clock, reset, rsp_valid |-> pos_ok, "texel out of row-major order")

   `BC1_ASSERT(a_alpha_code, clock, reset, rsp_valid |-> alpha_ok, "clear texel not black")

   `BC1_ASSERT(a_stall_hold, clock, reset, stalled |=> hold_ok, "stalled texel changed")

endmodule

bind bc1_block_decoder bc1_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_red        (rsp_chan.red),
   .rsp_green      (rsp_chan.green),
   .rsp_blue       (rsp_chan.blue),
   .rsp_alpha      (rsp_chan.alpha),
   .rsp_texel_col  (rsp_chan.texel_col),
   .rsp_texel_row  (rsp_chan.texel_row),
   .rsp_last_texel (rsp_chan.last_texel)
);
